// ----- hdl/rn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rn_pkg;

	// Fixed field widths
	localparam int SAMPLE_BITS = 16;
	localparam int NORM_BITS   = 24;

	// Input item: one row element
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          has_sample;
		logic                          row_last;
	} req_t;

	// Result item: one row norm
	typedef struct packed {
		logic [NORM_BITS-1:0] norm;
		logic                 saturated;
	} rsp_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_ROOT,
		ST_DONE
	} state_t;

	// Controls from sequencer to datapath
	typedef struct packed {
		logic in_ready;
		logic acc_en;
		logic root_start;
		logic root_step;
		logic alu_sub;
		logic out_load;
	} ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/rn_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared adder/subtractor: accumulate add or square-root trial subtract.
// carry is the add overflow, or "no borrow" (a >= b) for a subtract.
module rn_alu #(
	parameter int W = 48
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic      [W-1:0] res,
	output logic              carry
);

	logic [W-1:0] b_op;

	assign b_op = sub ? ~b : b;
	assign {carry, res} = {1'b0, a} + {1'b0, b_op} + (W+1)'(sub);

endmodule

`default_nettype wire

// ----- hdl/rn_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: accumulate step per element, then one root bit per cycle.
module rn_ctrl #(
	parameter int ROOT_BITS = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          has_sample,
	input  wire logic          row_last,
	input  wire logic          out_free,
	output rn_pkg::ctrl_t      ctrl
);

	localparam int CNT_W = $clog2(ROOT_BITS);
	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(ROOT_BITS - 1);

	rn_pkg::state_t   state_q;
	rn_pkg::state_t   state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rn_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Row-end mark and root bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (ctrl.in_ready && in_valid) begin
				last_q <= row_last;
			end
			if (ctrl.root_start) begin
				cnt_q <= CNT_INIT;
			end else if (ctrl.root_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Next state and controls
	always_comb begin
		state_nxt = state_q;
		ctrl      = '0;
		case (state_q)
			rn_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (in_valid) begin
					if (has_sample) begin
						state_nxt = rn_pkg::ST_ACC;
					end else if (row_last) begin
						ctrl.root_start = 1'b1;
						state_nxt       = rn_pkg::ST_ROOT;
					end
				end
			end
			rn_pkg::ST_ACC: begin
				ctrl.acc_en = 1'b1;
				if (last_q) begin
					ctrl.root_start = 1'b1;
					state_nxt       = rn_pkg::ST_ROOT;
				end else begin
					state_nxt = rn_pkg::ST_IDLE;
				end
			end
			rn_pkg::ST_ROOT: begin
				ctrl.root_step = 1'b1;
				ctrl.alu_sub   = 1'b1;
				if (cnt_q == '0) begin
					state_nxt = rn_pkg::ST_DONE;
				end
			end
			rn_pkg::ST_DONE: begin
				if (out_free) begin
					ctrl.out_load = 1'b1;
					state_nxt     = rn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rn_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/row_euclidean_norm_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Row Euclidean norm unit.
// req channel (valid/ready): one row element per item: signed Q1.15 sample,
// has_sample (element present) and row_last (closes the row). An item with
// neither flag set changes nothing. rsp channel (valid/ready): one item per
// row, norm = floor(sqrt(sum of squares)) in Q.15 (low 24 bits) plus a flag
// that the SUM_BITS-wide sum saturated during the row.
// Sequence: an element item is accepted with its square registered, then added
// in the shared adder. A row end computes ROOT_BITS = (SUM_BITS+1)/2 root
// bits, one root bit per cycle through the same adder, then loads the result
// register; no new item is taken until that load.
// req_ready is high only while the sequencer is idle.
// The result sits in an output register; if rsp_ready is low a finished row
// waits in the sequencer until that register frees, and no new item is taken.
// Reset clears the running sum, the clip flag, the sequencer and rsp_valid.
module row_euclidean_norm_unit #(
	parameter int SUM_BITS = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire rn_pkg::req_t  req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output rn_pkg::rsp_t       rsp
);

	localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int REM_BITS  = ROOT_BITS + 2;
	localparam int SQ_BITS   = 2 * rn_pkg::SAMPLE_BITS;
	localparam int NORM_W    = rn_pkg::NORM_BITS;

	rn_pkg::ctrl_t         ctrl;
	logic                  out_free;

	logic signed [SQ_BITS-1:0] prod;
	logic [SQ_BITS-1:0]    sq_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic                  clip_q;

	logic [RAD_BITS-1:0]   v_q;
	logic [REM_BITS-1:0]   r_q;
	logic [ROOT_BITS-1:0]  q_q;
	logic                  clip_row_q;

	logic [REM_BITS-1:0]   rs;
	logic [REM_BITS-1:0]   trial;
	logic [SUM_BITS-1:0]   alu_a;
	logic [SUM_BITS-1:0]   alu_b;
	logic [SUM_BITS-1:0]   alu_res;
	logic                  alu_carry;
	logic [SUM_BITS-1:0]   sum_new;
	logic                  clip_new;
	logic [SUM_BITS-1:0]   sum_fin;
	logic                  clip_fin;

	logic                  rsp_valid_q;
	rn_pkg::rsp_t          rsp_q;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = ctrl.in_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	rn_ctrl #(
		.ROOT_BITS(ROOT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.has_sample(req.has_sample),
		.row_last  (req.row_last),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	// Square of the incoming sample, registered at accept
	assign prod = req.sample * req.sample;

	always_ff @(posedge clk) begin
		if (req_valid && ctrl.in_ready) begin
			sq_q <= unsigned'(prod);
		end
	end

	// Operand select for the shared adder
	assign rs    = {r_q[REM_BITS-3:0], v_q[RAD_BITS-1 -: 2]};
	assign trial = {q_q, 2'b01};
	assign alu_a = ctrl.alu_sub ? SUM_BITS'(rs) : sum_q;
	assign alu_b = ctrl.alu_sub ? SUM_BITS'(trial) : SUM_BITS'(sq_q);

	rn_alu #(
		.W(SUM_BITS)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sub  (ctrl.alu_sub),
		.res  (alu_res),
		.carry(alu_carry)
	);

	// Saturating accumulate
	assign sum_new  = alu_carry ? '1 : alu_res;
	assign clip_new = clip_q | alu_carry;
	assign sum_fin  = ctrl.acc_en ? sum_new : sum_q;
	assign clip_fin = ctrl.acc_en ? clip_new : clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else if (ctrl.root_start) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else if (ctrl.acc_en) begin
			sum_q  <= sum_new;
			clip_q <= clip_new;
		end
	end

	// Digit-by-digit square root, one root bit per cycle
	always_ff @(posedge clk) begin
		if (ctrl.root_start) begin
			v_q        <= RAD_BITS'(sum_fin);
			r_q        <= '0;
			q_q        <= '0;
			clip_row_q <= clip_fin;
		end else if (ctrl.root_step) begin
			v_q <= v_q << 2;
			if (alu_carry) begin
				r_q <= alu_res[REM_BITS-1:0];
				q_q <= {q_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			rsp_q.norm      <= NORM_W'(q_q);
			rsp_q.saturated <= clip_row_q;
		end
	end

	// Checks
	a_elem_adds: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.has_sample |=> ctrl.acc_en)
		else $error("element item not followed by accumulate step");

	a_root_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.root_step |-> !req_ready)
		else $error("input ready during root iteration");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> out_free)
		else $error("result loaded over an untaken result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |=> rsp_valid)
		else $error("loaded result not presented");

	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.root_start |=> (sum_q == '0) && !clip_q)
		else $error("row sum not cleared at row end");

endmodule

`default_nettype wire
